// ===== rtl/pidd_pkg.sv =====
package pidd_pkg;

  localparam int POS_W      = 32;
  localparam int DUTY_W     = 18;
  localparam int GAIN_PI_W  = 24;
  localparam int GAIN_D_W   = 32;
  localparam int DUTY_CFG_W = 17;
  localparam int DBAND_W    = 16;
  localparam int SUM_W      = 48;
  localparam int CHG_W      = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // width of the exact term products and their sum
  localparam int TERM_W = 76;

  localparam int POSITION_WIDTH_DEF = 32;

  localparam logic [GAIN_PI_W-1:0]  KP_RST   = 24'd327680;
  localparam logic [GAIN_PI_W-1:0]  KI_RST   = 24'd0;
  localparam logic [GAIN_D_W-1:0]   KD_RST   = 32'd0;
  localparam logic [DUTY_CFG_W-1:0] MAXD_RST = 17'd52429;
  localparam logic [DUTY_CFG_W-1:0] MIND_RST = 17'd3277;
  localparam logic [DBAND_W-1:0]    DBAND_RST = 16'd1;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_MAXD = 3'd3,
    CFG_MIND = 3'd4,
    CFG_DBAND = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    logic                     done_res;
    logic signed [POS_W-1:0]  position_error;
  } out_item_t;

endpackage

// ===== rtl/position_pid_with_deadband_core.sv =====
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+------------------------------
// in_*      | input     | in_valid / in_stall | in_data (op, target, position)
// out_*     | output    | out_valid/out_stall | out_data (duty, done_res, error)
// cfg_*     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per clock unless stalled; each result is registered into the output
// register, or the skid entry while a result waits. the rate is set by the loop
// through the controller state: three gain multiplies, the term sum and the clamp.
// rst_n is synchronous; the output register plus a skid entry keep input
// transfers going while a result waits; in_stall is high on a full skid or rebuild.
// after a ki_gain or kd_gain write the stored term products are rebuilt in turn on
// one shared multiplier; in_stall is high and cfg_ready low meanwhile.
module position_pid_with_deadband_core #(
  parameter int POSITION_WIDTH = pidd_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pidd_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pidd_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PW  = pidd_pkg::POS_W;
  localparam int TW  = pidd_pkg::TERM_W;
  localparam int SW  = pidd_pkg::SUM_W;
  localparam int CW  = pidd_pkg::CHG_W;
  localparam int DW  = pidd_pkg::DUTY_W;
  localparam int DCW = pidd_pkg::DUTY_CFG_W;
  localparam int KW  = pidd_pkg::GAIN_PI_W;
  localparam int DGW = pidd_pkg::GAIN_D_W;
  localparam int HALF = SW / 2;

  // product-rebuild sequencer
  typedef enum logic [2:0] {
    RC_IDLE, RC_ILO, RC_IHI, RC_D, RC_KDP
  } rc_state_t;

  // configuration registers
  logic [KW-1:0]                  kp_r, ki_r;
  logic [DGW-1:0]                 kd_r;
  logic [DCW-1:0]                 max_duty_r, min_duty_r;
  logic [pidd_pkg::DBAND_W-1:0]   dband_r;

  // controller state
  logic signed [PW-1:0] goal_r;
  logic                 active_r;
  logic                 first_r;
  logic signed [PW-1:0] prev_err_r;
  logic signed [SW-1:0] err_sum_r;
  logic signed [CW-1:0] err_chg_r;
  // running products: ki*err_sum, kd*err_chg, kd*prev_err
  logic signed [TW-1:0] iterm_r, dterm_r, kdprev_r;

  rc_state_t            rc_state_r;
  logic signed [TW-1:0] rc_acc_r;

  // output register and skid entry
  logic                 out_v_r, skid_v_r;
  pidd_pkg::out_item_t  out_r, skid_r;

  logic in_fire, cfg_fire, out_fire;

  assign cfg_ready = (rc_state_r == RC_IDLE);
  assign in_stall  = skid_v_r || (rc_state_r != RC_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_fire  = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- error
  logic signed [PW-1:0] tgt_sx, pos_sx, err;
  logic signed [PW:0]   diff;
  logic [PW:0]          mag_w;
  logic                 in_band;

  assign tgt_sx = PW'($signed(in_data.target[POSITION_WIDTH-1:0]));
  assign pos_sx = PW'($signed(in_data.position[POSITION_WIDTH-1:0]));
  assign diff   = {goal_r[PW-1], goal_r} - {pos_sx[PW-1], pos_sx};

  always_comb begin
    if (diff[PW] != diff[PW-1]) begin
      // saturate to the 32-bit limits
      err = diff[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      err = diff[PW-1:0];
    end
  end

  assign mag_w   = err[PW-1] ? ((PW+1)'(0) - {err[PW-1], err}) : {1'b0, err};
  assign in_band = (mag_w[PW-1:0] <= {{(PW-pidd_pkg::DBAND_W){1'b0}}, dband_r});

  // ---------------------------------------------------------------- products
  logic signed [KW+PW:0]  kp_err_p, ki_err_p;
  logic signed [DGW+PW:0] kd_err_p;
  logic signed [TW-1:0]   kp_err, ki_err, kd_err;

  assign kp_err_p = $signed({1'b0, kp_r}) * err;
  assign ki_err_p = $signed({1'b0, ki_r}) * err;
  assign kd_err_p = $signed({1'b0, kd_r}) * err;
  assign kp_err   = TW'(kp_err_p);
  assign ki_err   = TW'(ki_err_p);
  assign kd_err   = TW'(kd_err_p);

  // duty before clamp: P of this sample plus I and D left by the previous one
  logic signed [TW-1:0] sum;
  logic [TW-1:0]        sum_mag;
  logic                 sum_neg, sum_zero, over_max, under_min;
  logic [DCW-1:0]       duty_mag;
  logic signed [DW-1:0] duty_val;
  logic                 grow;

  assign sum      = kp_err + iterm_r + dterm_r;
  assign sum_neg  = sum[TW-1];
  assign sum_zero = (sum == '0);
  assign sum_mag  = sum_neg ? (TW'(0) - sum) : sum;
  assign over_max = (sum_mag > TW'(max_duty_r));
  assign under_min = !sum_zero && (sum_mag < TW'(min_duty_r));

  always_comb begin
    grow = 1'b0;
    if (over_max) begin
      duty_mag = max_duty_r;
    end else if (under_min) begin
      duty_mag = min_duty_r;
    end else begin
      duty_mag = sum_mag[DCW-1:0];
      grow     = 1'b1;
    end
    duty_val = sum_neg ? (DW'(0) - {1'b0, duty_mag}) : {1'b0, duty_mag};
  end

  // integral update with saturation, keeping ki*err_sum in step
  logic signed [SW:0]   sum_add;
  logic signed [SW-1:0] err_sum_nxt;
  logic signed [TW-1:0] iterm_nxt, ki_ext, ki_top;

  assign sum_add = {err_sum_r[SW-1], err_sum_r} + (SW+1)'(err);
  assign ki_ext  = TW'($signed({1'b0, ki_r}));
  assign ki_top  = ki_ext <<< (SW-1);

  always_comb begin
    if (sum_add[SW] != sum_add[SW-1]) begin
      if (sum_add[SW]) begin
        err_sum_nxt = {1'b1, {(SW-1){1'b0}}};
        iterm_nxt   = TW'(0) - ki_top;
      end else begin
        err_sum_nxt = {1'b0, {(SW-1){1'b1}}};
        iterm_nxt   = ki_top - ki_ext;
      end
    end else begin
      err_sum_nxt = sum_add[SW-1:0];
      iterm_nxt   = iterm_r + ki_err;
    end
  end

  // ---------------------------------------------------------------- result
  pidd_pkg::out_item_t res;
  logic                 is_start, run_pid;

  assign is_start = (in_data.op == pidd_pkg::OP_START);
  assign run_pid  = !is_start && active_r && !in_band;

  always_comb begin
    res.duty           = '0;
    res.done_res       = 1'b1;
    res.position_error = err;
    if (is_start) begin
      res.done_res       = 1'b0;
      res.position_error = '0;
    end else if (run_pid) begin
      res.duty     = duty_val;
      res.done_res = 1'b0;
    end
  end

  // ---------------------------------------------------------------- rebuild
  logic [DGW-1:0]         rc_a;
  logic signed [CW-1:0]   rc_b;
  logic signed [DGW+CW:0] rc_prod;
  logic signed [TW-1:0]   rc_prod_x;

  always_comb begin
    rc_a = DGW'(ki_r);
    rc_b = CW'($signed({1'b0, err_sum_r[HALF-1:0]}));
    case (rc_state_r)
      RC_IHI: begin
        rc_b = CW'($signed(err_sum_r[SW-1:HALF]));
      end
      RC_D: begin
        rc_a = kd_r;
        rc_b = err_chg_r;
      end
      RC_KDP: begin
        rc_a = kd_r;
        rc_b = CW'(prev_err_r);
      end
      default: begin
        rc_a = DGW'(ki_r);
      end
    endcase
  end

  assign rc_prod   = $signed({1'b0, rc_a}) * rc_b;
  assign rc_prod_x = TW'(rc_prod);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= pidd_pkg::KP_RST;
      ki_r       <= pidd_pkg::KI_RST;
      kd_r       <= pidd_pkg::KD_RST;
      max_duty_r <= pidd_pkg::MAXD_RST;
      min_duty_r <= pidd_pkg::MIND_RST;
      dband_r    <= pidd_pkg::DBAND_RST;
      goal_r     <= '0;
      active_r   <= 1'b0;
      first_r    <= 1'b1;
      prev_err_r <= '0;
      err_sum_r  <= '0;
      err_chg_r  <= '0;
      iterm_r    <= '0;
      dterm_r    <= '0;
      kdprev_r   <= '0;
      rc_state_r <= RC_IDLE;
      rc_acc_r   <= '0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      // configuration writes; a ki or kd write starts the rebuild of the stored products
      if (cfg_fire) begin
        unique case (cfg_index)
          pidd_pkg::CFG_KP: begin
            kp_r <= cfg_data[KW-1:0];
          end
          pidd_pkg::CFG_KI: begin
            ki_r       <= cfg_data[KW-1:0];
            rc_state_r <= RC_ILO;
          end
          pidd_pkg::CFG_KD: begin
            kd_r       <= cfg_data[DGW-1:0];
            rc_state_r <= RC_ILO;
          end
          pidd_pkg::CFG_MAXD: begin
            max_duty_r <= cfg_data[DCW-1:0];
          end
          pidd_pkg::CFG_MIND: begin
            min_duty_r <= cfg_data[DCW-1:0];
          end
          pidd_pkg::CFG_DBAND: begin
            dband_r <= cfg_data[pidd_pkg::DBAND_W-1:0];
          end
          default: begin
            // unmapped index, write dropped
          end
        endcase
      end

      unique case (rc_state_r)
        RC_ILO: begin
          rc_acc_r   <= rc_prod_x;
          rc_state_r <= RC_IHI;
        end
        RC_IHI: begin
          iterm_r    <= (rc_prod_x <<< HALF) + rc_acc_r;
          rc_state_r <= RC_D;
        end
        RC_D: begin
          dterm_r    <= rc_prod_x;
          rc_state_r <= RC_KDP;
        end
        RC_KDP: begin
          kdprev_r   <= rc_prod_x;
          rc_state_r <= RC_IDLE;
        end
        default: begin
          // idle, nothing to rebuild
        end
      endcase

      // controller state
      if (in_fire) begin
        if (is_start) begin
          goal_r     <= tgt_sx;
          active_r   <= 1'b1;
          first_r    <= 1'b1;
          prev_err_r <= '0;
          err_sum_r  <= '0;
          err_chg_r  <= '0;
          iterm_r    <= '0;
          dterm_r    <= '0;
          kdprev_r   <= '0;
        end else if (active_r) begin
          if (in_band) begin
            active_r <= 1'b0;
          end else begin
            if (grow) begin
              err_sum_r <= err_sum_nxt;
              iterm_r   <= iterm_nxt;
            end
            if (!first_r) begin
              err_chg_r <= {err[PW-1], err} - {prev_err_r[PW-1], prev_err_r};
              dterm_r   <= kd_err - kdprev_r;
            end
            first_r    <= 1'b0;
            prev_err_r <= err;
            kdprev_r   <= kd_err;
          end
        end
      end

      // output register with one skid entry
      if (!out_v_r || out_fire) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

endmodule
